// File: src/rbd_pkg.sv
// Shared types, constants and register codes for the retry back-off delay block.
`default_nettype none

package rbd_pkg;

    // Field widths.
    localparam int TIME_BITS        = 20;
    localparam int FACTOR_FRAC_BITS = 8;
    localparam int FACTOR_W         = 12;
    localparam int CNT_W            = 6;
    localparam int RND_W            = 16;

    // Jitter is unsigned Q1.17 and covers [0.75, 1.25).
    localparam int JITTER_FRAC_BITS = 17;
    localparam int JITTER_W         = JITTER_FRAC_BITS + 1;
    localparam logic [JITTER_W-1:0] JITTER_BASE = JITTER_W'(3) << (JITTER_FRAC_BITS - 2);

    // Working delay register: holds the saturation cap and the jittered cap.
    localparam int ACC_W  = TIME_BITS + 4;
    localparam int PROD_W = ACC_W + JITTER_W;
    localparam logic [ACC_W-1:0]    DELAY_CAP  = ACC_W'(1) << (TIME_BITS + 2);
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FACTOR_FRAC_BITS;

    // Register reset values.
    localparam logic                 RETRY_ON_RST   = 1'b1;
    localparam logic [TIME_BITS-1:0] BASE_DELAY_RST = TIME_BITS'(1000);
    localparam logic [FACTOR_W-1:0]  GROWTH_RST     = FACTOR_W'(640);
    localparam logic [TIME_BITS-1:0] BUDGET_RST     = TIME_BITS'(60000);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_RETRY_ON   = 2'd0,
        REG_BASE_DELAY = 2'd1,
        REG_GROWTH     = 2'd2,
        REG_BUDGET     = 2'd3
    } rbd_reg_idx_t;

    // Operation of the shared scaling unit.
    typedef enum logic {
        OP_GROW   = 1'b0,
        OP_JITTER = 1'b1
    } rbd_op_t;

    typedef struct packed {
        logic                 retry_on;
        logic [TIME_BITS-1:0] base_delay;
        logic [FACTOR_W-1:0]  growth_factor;
        logic [TIME_BITS-1:0] wait_budget;
    } rbd_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]     attempt_count;
        logic [TIME_BITS-1:0] spent_wait;
        logic [RND_W-1:0]     random_word;
    } rbd_in_t;

    typedef struct packed {
        logic                 retry_ok;
        logic [TIME_BITS-1:0] wait_ms;
    } rbd_out_t;

endpackage

`default_nettype wire

// File: src/rbd_cfg_regs.sv
// Configuration register file of the retry back-off delay block.
`default_nettype none

module rbd_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire rbd_pkg::rbd_reg_idx_t         cfg_index,
    input  wire logic [rbd_pkg::TIME_BITS-1:0] cfg_data,
    output rbd_pkg::rbd_cfg_t                  cfg
);
    import rbd_pkg::*;

    rbd_cfg_t cfg_reg;

    // Registers are written whenever the write enable is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_on      <= RETRY_ON_RST;
            cfg_reg.base_delay    <= BASE_DELAY_RST;
            cfg_reg.growth_factor <= GROWTH_RST;
            cfg_reg.wait_budget   <= BUDGET_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RETRY_ON:   cfg_reg.retry_on      <= cfg_data[0];
                REG_BASE_DELAY: cfg_reg.base_delay    <= cfg_data;
                REG_GROWTH:     cfg_reg.growth_factor <= cfg_data[FACTOR_W-1:0];
                REG_BUDGET:     cfg_reg.wait_budget   <= cfg_data;
                default:        cfg_reg.retry_on      <= cfg_reg.retry_on;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/rbd_scale_unit.sv
// Shared multiplier that applies either one growth step or the jitter to the delay.
`default_nettype none

module rbd_scale_unit (
    input  wire logic [rbd_pkg::ACC_W-1:0]    acc,
    input  wire rbd_pkg::rbd_op_t             op,
    input  wire logic [rbd_pkg::FACTOR_W-1:0] growth_factor,
    input  wire logic [rbd_pkg::RND_W-1:0]    random_word,
    output logic [rbd_pkg::ACC_W-1:0]         acc_next
);
    import rbd_pkg::*;

    localparam int GROW_W = PROD_W - FACTOR_FRAC_BITS;
    localparam int JIT_SH_W = PROD_W - JITTER_FRAC_BITS;

    logic [FACTOR_W-1:0] factor_eff;
    logic [JITTER_W-1:0] multiplier;
    logic [PROD_W-1:0]   product;
    logic [GROW_W-1:0]   grown;
    logic [JIT_SH_W-1:0] jittered;

    // Factors below 1.0 act as 1.0.
    assign factor_eff = (growth_factor < FACTOR_ONE) ? FACTOR_ONE : growth_factor;

    // Select the second operand and form the single product.
    always_comb
    begin
        unique case (op)
            OP_GROW:   multiplier = JITTER_W'(factor_eff);
            OP_JITTER: multiplier = JITTER_BASE + JITTER_W'(random_word);
            default:   multiplier = JITTER_W'(factor_eff);
        endcase
    end

    assign product  = PROD_W'(acc) * PROD_W'(multiplier);
    assign grown    = product[PROD_W-1:FACTOR_FRAC_BITS];
    assign jittered = product[PROD_W-1:JITTER_FRAC_BITS];

    // Truncate and, on a growth step, saturate at the cap.
    always_comb
    begin
        unique case (op)
            OP_GROW:
            begin
                if (grown > GROW_W'(DELAY_CAP))
                    acc_next = DELAY_CAP;
                else
                    acc_next = grown[ACC_W-1:0];
            end
            OP_JITTER: acc_next = jittered[ACC_W-1:0];
            default:   acc_next = grown[ACC_W-1:0];
        endcase
    end

endmodule

`default_nettype wire

// File: src/retry_backoff_delay_top.sv
// Top level of the retry back-off delay block: sequencer and result register.
//
// Usage: a request beat (attempt count, wait already spent, random word) is taken
// at a clock edge where start is high and busy is low. The block then stays busy
// while one shared multiplier applies the growth factor once per attempt, then
// the jitter, and finally the result is clamped to at least 1 ms and at most the
// remaining budget. The result beat appears on result for exactly one cycle,
// marked by done; done comes with busy low, so a new start may be given in the
// same cycle.
// Sequence: after the accepting edge the sequencer passes through S_GROW for each
// attempt, then S_JITTER and S_FINISH, which registers result and done; a
// request that gives no retry goes straight to S_FINISH. The multiply loop keeps
// busy high, so a new request is taken only once the last one is done.
// Configuration: cfg_wr_en, cfg_index and cfg_data write one register per edge;
// there is no read-back. Write only while the block is idle (not enforced).
// Reset: rst_n clears the sequencer and loads the register defaults (retries
// on, 1000 ms base, factor 2.5, 60000 ms budget). The receiver cannot stall.
`default_nettype none

module retry_backoff_delay_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire rbd_pkg::rbd_in_t              item,
    input  wire logic                          cfg_wr_en,
    input  wire rbd_pkg::rbd_reg_idx_t         cfg_index,
    input  wire logic [rbd_pkg::TIME_BITS-1:0] cfg_data,
    output logic                               done,
    output rbd_pkg::rbd_out_t                  result
);
    import rbd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROW,
        S_JITTER,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [TIME_BITS-1:0] remain_reg, remain_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    logic                 ok_reg, ok_next;
    logic                 done_reg, done_next;
    rbd_out_t             result_reg, result_next;

    rbd_cfg_t             cfg;
    rbd_op_t              op;
    logic [ACC_W-1:0]     unit_out;
    logic                 no_retry;
    logic [TIME_BITS-1:0] clamped;

    rbd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign op = (state_reg == S_JITTER) ? OP_JITTER : OP_GROW;

    rbd_scale_unit u_scale (
        .acc           (acc_reg),
        .op            (op),
        .growth_factor (cfg.growth_factor),
        .random_word   (rnd_reg),
        .acc_next      (unit_out)
    );

    // A request gives no retry when retries are off, the base delay or the budget
    // is zero, or the budget is used up.
    assign no_retry = !cfg.retry_on || (cfg.base_delay == '0) || (cfg.wait_budget == '0)
                      || (item.spent_wait >= cfg.wait_budget);

    // Clamp the jittered delay to at least one and at most the remaining budget.
    always_comb
    begin
        if (acc_reg == '0)
            clamped = TIME_BITS'(1);
        else if (acc_reg > ACC_W'(remain_reg))
            clamped = remain_reg;
        else
            clamped = acc_reg[TIME_BITS-1:0];
    end

    // Sequencer next-state and datapath register updates.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        rnd_next    = rnd_reg;
        ok_next     = ok_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    count_next  = item.attempt_count;
                    acc_next    = ACC_W'(cfg.base_delay);
                    remain_next = cfg.wait_budget - item.spent_wait;
                    rnd_next    = item.random_word;
                    ok_next     = !no_retry;
                    if (no_retry)
                        state_next = S_FINISH;
                    else if (item.attempt_count == '0)
                        state_next = S_JITTER;
                    else
                        state_next = S_GROW;
                end
            end
            S_GROW:
            begin
                acc_next   = unit_out;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                    state_next = S_JITTER;
            end
            S_JITTER:
            begin
                acc_next   = unit_out;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done_next            = 1'b1;
                result_next.retry_ok = ok_reg;
                result_next.wait_ms  = ok_reg ? clamped : '0;
                state_next           = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        acc_reg    <= acc_next;
        remain_reg <= remain_next;
        rnd_reg    <= rnd_next;
        ok_reg     <= ok_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The result beat only appears once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // A strobe lasts a single cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // No retry always reports a zero delay.
    a_no_retry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.retry_ok) |-> (result.wait_ms == '0))
        else $error("nonzero delay without retry");

    // A scheduled retry never has a zero delay.
    a_retry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.retry_ok) |-> (result.wait_ms != '0))
        else $error("zero delay on a scheduled retry");

    // An accepted request always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

endmodule

`default_nettype wire

// File: test/retry_backoff_delay_top_tb.sv
// Testbench for the retry back-off delay block: directed and random requests against a predictor.
`timescale 1ns / 1ps

module retry_backoff_delay_top_tb;

    import rbd_pkg::*;

    // Arithmetic constants of the back-off computation, at 64 bits.
    localparam longint unsigned GROWTH_UNITY  = 64'd1 << FACTOR_FRAC_BITS;
    localparam longint unsigned GROWTH_CAP    = 64'd1 << (TIME_BITS + 2);
    localparam longint unsigned JITTER_OFFSET = 64'h18000;
    localparam int              JITTER_SHIFT  = 17;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASE_COUNT     = 11;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PRINT_LIMIT     = 20;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    rbd_in_t              item;
    logic                 cfg_wr_en;
    rbd_reg_idx_t         cfg_index;
    logic [TIME_BITS-1:0] cfg_data;
    logic                 done;
    rbd_out_t             result;

    // Shadow copy of the block's registers.
    logic                 cur_retry_on;
    logic [TIME_BITS-1:0] cur_base_delay;
    logic [FACTOR_W-1:0]  cur_growth;
    logic [TIME_BITS-1:0] cur_budget;

    rbd_out_t expected_waits[$];
    int       error_count = 0;
    int       cycle_count = 0;
    bit       no_idle = 1'b0;

    retry_backoff_delay_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected delay for one request under the current register settings.
    function automatic rbd_out_t predict_backoff(rbd_in_t req);
        rbd_out_t        res;
        longint unsigned delay;
        longint unsigned factor;
        longint unsigned remaining;
        int              step;
        res = '0;
        if (!cur_retry_on || cur_budget == 0 || cur_base_delay == 0
            || req.spent_wait >= cur_budget)
        begin
            return res;
        end
        remaining = longint'(cur_budget) - longint'(req.spent_wait);
        factor = (cur_growth < GROWTH_UNITY) ? GROWTH_UNITY : longint'(cur_growth);
        delay = cur_base_delay;
        // Grow once per attempt; once past the cap the delay sticks there.
        for (step = 0; step < req.attempt_count; step++)
        begin
            delay = (delay * factor) >> FACTOR_FRAC_BITS;
            if (delay > GROWTH_CAP)
            begin
                delay = GROWTH_CAP;
                break;
            end
        end
        delay = (delay * (JITTER_OFFSET + req.random_word)) >> JITTER_SHIFT;
        if (delay < 1)
            delay = 1;
        if (delay > remaining)
            delay = remaining;
        res.retry_ok = 1'b1;
        res.wait_ms  = delay[TIME_BITS-1:0];
        return res;
    endfunction

    function automatic rbd_in_t make_req(int cnt, int spent, int rnd);
        rbd_in_t req;
        req.attempt_count = CNT_W'(cnt);
        req.spent_wait    = TIME_BITS'(spent);
        req.random_word   = RND_W'(rnd);
        return req;
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_beat
        rbd_out_t want;
        if (rst_n && done)
        begin
            if (expected_waits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat: retry_ok=%0d wait_ms=%0d",
                                          result.retry_ok, result.wait_ms));
            end
            else
            begin
                want = expected_waits.pop_front();
                if (result.retry_ok !== want.retry_ok)
                    report_mismatch($sformatf("retry_ok got %0d want %0d",
                                              result.retry_ok, want.retry_ok));
                if (result.wait_ms !== want.wait_ms)
                    report_mismatch($sformatf("wait_ms got %0d want %0d",
                                              result.wait_ms, want.wait_ms));
            end
        end
    end

    // Watchdog: end the run if it never drains.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Send one request beat, with an occasional gap before it.
    task automatic send_request(rbd_in_t req);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 8)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= req;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        expected_waits.push_back(predict_backoff(req));
        // Drop start so the same beat is not taken again once the block is idle.
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Wait until every expected beat has come and the block is idle.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_waits.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Registers are only written once every request in flight has finished.
    task automatic write_reg(rbd_reg_idx_t idx, logic [TIME_BITS-1:0] data);
        @(negedge clk);
        while (busy || expected_waits.size() != 0)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_RETRY_ON:   cur_retry_on   = data[0];
            REG_BASE_DELAY: cur_base_delay = data;
            REG_GROWTH:     cur_growth     = data[FACTOR_W-1:0];
            REG_BUDGET:     cur_budget     = data;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Requests under the reset settings: 1000 ms base, factor 2.5, 60000 ms budget.
    task automatic test_reset_values();
        send_request(make_req(0, 0, 0));
        send_request(make_req(0, 0, 16'hFFFF));
        send_request(make_req(3, 12345, 16'h8000));
        send_request(make_req(63, 0, 16'hFFFF));
        send_request(make_req(2, 59999, 16'h1234));
        send_request(make_req(1, 60000, 0));
        send_request(make_req(63, TIME_MAX, 16'hFFFF));
        drain_results();
    endtask

    // Each register that can switch retries off, with junk in the upper data bits.
    task automatic test_no_retry_cases();
        write_reg(REG_RETRY_ON, 20'hFFFFE);
        send_request(make_req(4, 100, 16'h5555));
        write_reg(REG_RETRY_ON, 20'h00001);
        write_reg(REG_BASE_DELAY, '0);
        send_request(make_req(4, 100, 16'hAAAA));
        write_reg(REG_BASE_DELAY, TIME_BITS'(1000));
        write_reg(REG_BUDGET, '0);
        send_request(make_req(0, 0, 0));
        write_reg(REG_BUDGET, TIME_BITS'(60000));
        drain_results();
    endtask

    // Truncation to zero is raised to 1 ms; factors below 1.0 act as 1.0.
    task automatic test_floor_and_unity();
        write_reg(REG_BASE_DELAY, TIME_BITS'(1));
        write_reg(REG_GROWTH, 20'hFF000);
        send_request(make_req(5, 0, 0));
        write_reg(REG_GROWTH, TIME_BITS'(255));
        send_request(make_req(63, 0, 0));
        write_reg(REG_GROWTH, TIME_BITS'(256));
        send_request(make_req(63, 0, 16'hFFFF));
        drain_results();
    endtask

    // Largest base, factor and budget: saturation and the budget clamp.
    task automatic test_saturation_extremes();
        write_reg(REG_BASE_DELAY, TIME_MAX);
        write_reg(REG_GROWTH, TIME_MAX);
        write_reg(REG_BUDGET, TIME_MAX);
        send_request(make_req(0, 0, 0));
        send_request(make_req(1, 0, 16'hFFFF));
        send_request(make_req(63, 0, 16'hFFFF));
        send_request(make_req(63, TIME_MAX - 1, 16'hFFFF));
        send_request(make_req(7, TIME_MAX, 16'h0001));
        drain_results();
    endtask

    // Pick a register setting, weighted toward the extremes and useful ranges.
    task automatic pick_config(int phase);
        logic [TIME_BITS-1:0] on_word;
        logic [TIME_BITS-1:0] base;
        logic [TIME_BITS-1:0] growth;
        logic [TIME_BITS-1:0] budget;
        on_word = TIME_BITS'($urandom);
        on_word[0] = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0:       base = '0;
            1:       base = TIME_BITS'(1);
            2:       base = TIME_MAX;
            3, 4:    base = TIME_BITS'($urandom);
            default: base = TIME_BITS'($urandom_range(1, 5000));
        endcase
        case ($urandom_range(0, 9))
            0:       growth = TIME_BITS'($urandom_range(0, 255));
            1:       growth = TIME_BITS'(256);
            2:       growth = TIME_BITS'(4095);
            3:       growth = TIME_BITS'($urandom);
            default: growth = TIME_BITS'($urandom_range(256, 1024));
        endcase
        case ($urandom_range(0, 9))
            0:       budget = '0;
            1:       budget = TIME_MAX;
            2:       budget = TIME_BITS'($urandom_range(1, 100));
            default: budget = TIME_BITS'($urandom);
        endcase
        // Fixed settings at both ends of the ranges.
        if (phase == 1)
        begin
            on_word = TIME_MAX;
            base    = TIME_MAX;
            growth  = TIME_MAX;
            budget  = TIME_MAX;
        end
        else if (phase == 2)
        begin
            on_word = TIME_BITS'(1);
            base    = TIME_BITS'(1);
            growth  = '0;
            budget  = TIME_BITS'(1);
        end
        write_reg(REG_RETRY_ON, on_word);
        write_reg(REG_BASE_DELAY, base);
        write_reg(REG_GROWTH, growth);
        write_reg(REG_BUDGET, budget);
    endtask

    // Random requests over several settings; the first phase never idles.
    task automatic test_random_traffic();
        rbd_in_t req;
        int      phase;
        int      n;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            pick_config(phase);
            no_idle = (phase == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                req.random_word = RND_W'($urandom);
                if ($urandom_range(0, 9) < 7)
                    req.attempt_count = CNT_W'($urandom_range(0, 15));
                else
                    req.attempt_count = CNT_W'($urandom);
                // Mostly within budget so the delay path is exercised.
                if (cur_budget != 0 && $urandom_range(0, 3) != 0)
                    req.spent_wait = TIME_BITS'($urandom_range(0, cur_budget - 1));
                else
                    req.spent_wait = TIME_BITS'($urandom);
                send_request(req);
            end
            no_idle = 1'b0;
            drain_results();
        end
    endtask

    initial
    begin
        start     = 1'b0;
        item      = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_RETRY_ON;
        cfg_data  = '0;
        rst_n     = 1'b0;
        cur_retry_on   = 1'b1;
        cur_base_delay = TIME_BITS'(1000);
        cur_growth     = FACTOR_W'(640);
        cur_budget     = TIME_BITS'(60000);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_no_retry_cases();
        test_floor_and_unity();
        test_saturation_extremes();
        test_random_traffic();
        drain_results();
        repeat (8) @(negedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/rbd_pkg.sv
src/rbd_cfg_regs.sv
src/rbd_scale_unit.sv
src/retry_backoff_delay_top.sv
test/retry_backoff_delay_top_tb.sv
